// ----- design/rmcs_pkg.sv -----
// Package for the road mask centerline scan core.
// Holds sizes, register indexes, reset values, the result record and the size clamp.
// No dependencies.
package rmcs_pkg;

  localparam int MAX_DIM_BITS = 12;
  localparam int DIM_W        = MAX_DIM_BITS;
  localparam int LEN_W        = DIM_W + 1;
  localparam int CFG_DIM_W    = 13;
  localparam int CMP_W        = (LEN_W > CFG_DIM_W) ? LEN_W : CFG_DIM_W;
  localparam int MAX_DIM      = 1 << MAX_DIM_BITS;

  localparam int LABEL_W      = 8;
  localparam int STEP_W       = 8;
  localparam int MIN_W_W      = 12;
  localparam int SPAN_CMP_W   = (DIM_W > MIN_W_W) ? DIM_W : MIN_W_W;
  localparam int APP_W        = 32;
  localparam int TOTAL_W      = 2 * DIM_W + 1;
  localparam int PROD_W       = TOTAL_W + APP_W;

  localparam int CENTRE_W     = 13;
  localparam int ROW_IDX_W    = 12;
  localparam int AREA_W       = 56;
  localparam int OUT_DATA_W   = 88;
  localparam int IN_DATA_W    = 8;

  localparam int REG_ADDR_W   = 3;
  localparam int REG_DATA_W   = 32;

  localparam logic [REG_ADDR_W-1:0] REG_ROAD_CLASS     = 3'd0;
  localparam logic [REG_ADDR_W-1:0] REG_FRAME_WIDTH    = 3'd1;
  localparam logic [REG_ADDR_W-1:0] REG_FRAME_HEIGHT   = 3'd2;
  localparam logic [REG_ADDR_W-1:0] REG_ROW_STEP       = 3'd3;
  localparam logic [REG_ADDR_W-1:0] REG_MIN_WIDTH      = 3'd4;
  localparam logic [REG_ADDR_W-1:0] REG_AREA_PER_PIXEL = 3'd5;

  localparam int RESET_WIDTH   = 640;
  localparam int RESET_HEIGHT  = 480;
  localparam int RESET_STEP    = 10;
  localparam int RESET_MIN_W   = 10;
  localparam int RESET_APP     = 65536;
  localparam int RESET_H_CLAMP = (RESET_HEIGHT > MAX_DIM) ? MAX_DIM : RESET_HEIGHT;
  localparam int RESET_PHASE   = (RESET_H_CLAMP - 1) % RESET_STEP;

  localparam logic KIND_POINT = 1'b0;
  localparam logic KIND_AREA  = 1'b1;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = 2;
  localparam int FIFO_CNT_W = 3;

  typedef struct packed {
    logic                 kind;
    logic [CENTRE_W-1:0]  centre_twice;
    logic [ROW_IDX_W-1:0] row_index;
    logic [AREA_W-1:0]    road_area;
    logic                 frame_last;
  } result_t;

  function automatic logic [LEN_W-1:0] clamp_dim(input logic [CFG_DIM_W-1:0] v);
    logic [CMP_W-1:0] ext;
    ext = CMP_W'(v);
    if (ext == '0) begin
      return LEN_W'(1);
    end else if (ext > CMP_W'(MAX_DIM)) begin
      return LEN_W'(MAX_DIM);
    end
    return LEN_W'(ext);
  endfunction

endpackage

// ----- design/road_mask_centerline_scan_core.sv -----
// Road mask centerline scan core: per-pixel road test, row span tracking,
// centre point and frame area results. Depends on rmcs_pkg.
//
// Takes one class-label pixel per clock in raster order into the s1 input register and writes
// each result from there into a four-entry result queue. The input stalls only when
// the queue has fewer than two free entries (the last row of a frame can give a point and
// the area result from one pixel) or while the sampling phase is recomputed: after any
// write to frame_height or row_step, a bit-serial remainder unit runs its LOAD0, RUN0,
// LOAD1 and RUN1 states, during which no pixel is taken or processed. Reset loads the
// phase for the reset values directly. Configuration writes take effect on every pixel
// not yet processed.
module road_mask_centerline_scan_core (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_wr_en,
  input  logic [rmcs_pkg::REG_ADDR_W-1:0]       cfg_addr,
  input  logic [rmcs_pkg::REG_DATA_W-1:0]       cfg_data,
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  input  logic [rmcs_pkg::IN_DATA_W-1:0]        s_axis_tdata,  // [7:0] class_label
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  // [12:0] centre_twice, [24:13] row_index, [80:25] road_area, [87:81] zero
  output logic [rmcs_pkg::OUT_DATA_W-1:0]       m_axis_tdata,
  output logic                                  m_axis_tuser,  // [0] kind
  output logic                                  m_axis_tlast   // frame_last
);
  import rmcs_pkg::*;

  localparam logic [2:0] DIV_IDLE  = 3'd0;
  localparam logic [2:0] DIV_LOAD0 = 3'd1;
  localparam logic [2:0] DIV_RUN0  = 3'd2;
  localparam logic [2:0] DIV_LOAD1 = 3'd3;
  localparam logic [2:0] DIV_RUN1  = 3'd4;
  localparam int         CNT_W     = $clog2(DIM_W);

  logic [LABEL_W-1:0]   road_class;
  logic [CFG_DIM_W-1:0] frame_width;
  logic [CFG_DIM_W-1:0] frame_height;
  logic [STEP_W-1:0]    row_step;
  logic [MIN_W_W-1:0]   min_width;
  logic [APP_W-1:0]     area_per_pixel;

  logic [DIM_W-1:0]     column_count;
  logic [DIM_W-1:0]     row_count;
  logic [DIM_W-1:0]     first_column;
  logic [DIM_W-1:0]     last_column;
  logic                 span_seen;
  logic [TOTAL_W-1:0]   road_pixel_total;
  logic [STEP_W-1:0]    row_phase;
  logic [STEP_W-1:0]    frame_phase;

  logic                 s1_valid;
  logic [LABEL_W-1:0]   s1_label;

  result_t              fifo [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr;
  logic [FIFO_PTR_W-1:0] rd_ptr;
  logic [FIFO_CNT_W-1:0] count;

  logic [2:0]           div_state;
  logic [DIM_W-1:0]     div_shift;
  logic [STEP_W-1:0]    rem;
  logic [CNT_W-1:0]     bit_cnt;

  logic [LEN_W-1:0]     width_len;
  logic [LEN_W-1:0]     height_len;
  logic [STEP_W-1:0]    divisor;
  logic                 busy;
  logic                 room;
  logic                 s1_go;
  logic                 pop;
  logic                 is_road;
  logic [DIM_W-1:0]     first_upd;
  logic [DIM_W-1:0]     last_upd;
  logic                 seen_upd;
  logic [TOTAL_W-1:0]   total_upd;
  logic                 row_end;
  logic                 frame_end;
  logic                 in_range;
  logic                 lower_half;
  logic                 sampled;
  logic [DIM_W-1:0]     span;
  logic                 point;
  logic [PROD_W-1:0]    product;
  result_t              point_res;
  result_t              area_res;
  logic [FIFO_CNT_W-1:0] n_push;
  logic [STEP_W:0]      trial;
  logic [STEP_W-1:0]    rem_next;
  logic                 div_last;
  logic [DIM_W-1:0]     dividend1;

  assign width_len  = clamp_dim(frame_width);
  assign height_len = clamp_dim(frame_height);
  assign divisor    = (row_step == '0) ? STEP_W'(1) : row_step;
  assign busy       = (div_state != DIV_IDLE);
  assign room       = (count <= FIFO_CNT_W'(FIFO_DEPTH - 2));
  assign s1_go      = s1_valid && room && !busy;
  assign s_axis_tready = !busy && (!s1_valid || room);
  assign pop        = m_axis_tvalid && m_axis_tready;

  always_comb begin
    is_road    = (s1_label == road_class);
    first_upd  = (is_road && !span_seen) ? column_count : first_column;
    last_upd   = is_road ? column_count : last_column;
    seen_upd   = span_seen || is_road;
    total_upd  = road_pixel_total + TOTAL_W'(is_road);
    row_end    = (LEN_W'(column_count) + LEN_W'(1)) >= width_len;
    frame_end  = row_end && ((LEN_W'(row_count) + LEN_W'(1)) >= height_len);
    in_range   = LEN_W'(row_count) <= (height_len - LEN_W'(1));
    lower_half = {row_count, 1'b0} > height_len;
    sampled    = in_range && (row_phase == '0) && lower_half;
    span       = last_upd - first_upd;
    point      = row_end && sampled && seen_upd &&
                 (SPAN_CMP_W'(span) > SPAN_CMP_W'(min_width));
    product    = PROD_W'(total_upd) * PROD_W'(area_per_pixel);

    point_res              = '0;
    point_res.kind         = KIND_POINT;
    point_res.centre_twice = CENTRE_W'(LEN_W'(first_upd) + LEN_W'(last_upd));
    point_res.row_index    = ROW_IDX_W'(row_count);

    area_res            = '0;
    area_res.kind       = KIND_AREA;
    area_res.road_area  = AREA_W'(product);
    area_res.frame_last = 1'b1;

    n_push = '0;
    if (s1_go) begin
      n_push = FIFO_CNT_W'(point) + FIFO_CNT_W'(frame_end);
    end
  end

  always_comb begin
    trial     = {rem, div_shift[DIM_W-1]};
    rem_next  = (trial >= {1'b0, divisor}) ? STEP_W'(trial - {1'b0, divisor})
                                           : STEP_W'(trial);
    div_last  = (bit_cnt == CNT_W'(DIM_W - 1));
    dividend1 = in_range ? DIM_W'(height_len - LEN_W'(1) - LEN_W'(row_count)) : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      road_class     <= '0;
      frame_width    <= CFG_DIM_W'(RESET_WIDTH);
      frame_height   <= CFG_DIM_W'(RESET_HEIGHT);
      row_step       <= STEP_W'(RESET_STEP);
      min_width      <= MIN_W_W'(RESET_MIN_W);
      area_per_pixel <= APP_W'(RESET_APP);
    end else if (cfg_wr_en) begin
      case (cfg_addr)
        REG_ROAD_CLASS:     road_class     <= cfg_data[LABEL_W-1:0];
        REG_FRAME_WIDTH:    frame_width    <= cfg_data[CFG_DIM_W-1:0];
        REG_FRAME_HEIGHT:   frame_height   <= cfg_data[CFG_DIM_W-1:0];
        REG_ROW_STEP:       row_step       <= cfg_data[STEP_W-1:0];
        REG_MIN_WIDTH:      min_width      <= cfg_data[MIN_W_W-1:0];
        REG_AREA_PER_PIXEL: area_per_pixel <= cfg_data[APP_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      div_state   <= DIV_IDLE;
      frame_phase <= STEP_W'(RESET_PHASE);
      bit_cnt     <= '0;
    end else if (cfg_wr_en &&
                 (cfg_addr == REG_FRAME_HEIGHT || cfg_addr == REG_ROW_STEP)) begin
      div_state <= DIV_LOAD0;
    end else begin
      case (div_state)
        DIV_LOAD0: begin
          div_shift <= DIM_W'(height_len - LEN_W'(1));
          rem       <= '0;
          bit_cnt   <= '0;
          div_state <= DIV_RUN0;
        end
        DIV_LOAD1: begin
          div_shift <= dividend1;
          rem       <= '0;
          bit_cnt   <= '0;
          div_state <= DIV_RUN1;
        end
        DIV_RUN0, DIV_RUN1: begin
          rem       <= rem_next;
          div_shift <= div_shift << 1;
          bit_cnt   <= bit_cnt + CNT_W'(1);
          if (div_last) begin
            if (div_state == DIV_RUN0) begin
              frame_phase <= rem_next;
              div_state   <= DIV_LOAD1;
            end else begin
              div_state   <= DIV_IDLE;
            end
          end
        end
        default: div_state <= DIV_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_axis_tready) begin
      s1_valid <= s_axis_tvalid;
    end else if (s1_go) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      s1_label <= s_axis_tdata[LABEL_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count     <= '0;
      row_count        <= '0;
      first_column     <= '0;
      last_column      <= '0;
      span_seen        <= 1'b0;
      road_pixel_total <= '0;
      row_phase        <= STEP_W'(RESET_PHASE);
    end else if ((div_state == DIV_RUN1) && div_last) begin
      row_phase <= rem_next;
    end else if (s1_go) begin
      if (row_end) begin
        column_count <= '0;
        first_column <= '0;
        last_column  <= '0;
        span_seen    <= 1'b0;
        if (frame_end) begin
          row_count        <= '0;
          road_pixel_total <= '0;
          row_phase        <= frame_phase;
        end else begin
          row_count        <= row_count + DIM_W'(1);
          road_pixel_total <= total_upd;
          row_phase        <= (row_phase == '0) ? divisor - STEP_W'(1)
                                                : row_phase - STEP_W'(1);
        end
      end else begin
        column_count     <= column_count + DIM_W'(1);
        first_column     <= first_upd;
        last_column      <= last_upd;
        span_seen        <= seen_upd;
        road_pixel_total <= total_upd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && point) begin
      fifo[wr_ptr] <= point_res;
    end
    if (s1_go && frame_end) begin
      fifo[point ? wr_ptr + FIFO_PTR_W'(1) : wr_ptr] <= area_res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + FIFO_PTR_W'(n_push);
      if (pop) begin
        rd_ptr <= rd_ptr + FIFO_PTR_W'(1);
      end
      count <= count + n_push - FIFO_CNT_W'(pop);
    end
  end

  assign m_axis_tvalid = (count != '0);
  assign m_axis_tuser  = fifo[rd_ptr].kind;
  assign m_axis_tlast  = fifo[rd_ptr].frame_last;
  assign m_axis_tdata  = OUT_DATA_W'({fifo[rd_ptr].road_area,
                                      fifo[rd_ptr].row_index,
                                      fifo[rd_ptr].centre_twice});

  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    count <= FIFO_CNT_W'(FIFO_DEPTH))
    else $error("result queue overfilled");

  a_phase_range: assert property (@(posedge clk) disable iff (rst)
    (div_state == DIV_IDLE) |-> (row_phase < divisor && frame_phase < divisor))
    else $error("sampling phase out of range");

  a_frame_clear: assert property (@(posedge clk) disable iff (rst)
    (s1_go && frame_end) |=> (row_count == '0 && road_pixel_total == '0))
    else $error("frame counters not cleared at frame end");

  a_span_order: assert property (@(posedge clk) disable iff (rst)
    span_seen |-> (first_column <= last_column))
    else $error("road span inverted");

endmodule

// ----- dv/road_mask_centerline_scan_core_test.sv -----
`timescale 1ns / 1ps
// Self-checking bench for road_mask_centerline_scan_core: streams class-label pixels, predicts
// centre points and frame road areas, and compares every result on the output stream.
// Depends on rmcs_pkg and the core.
module road_mask_centerline_scan_core_test;
  import rmcs_pkg::*;

  localparam int CYCLE_LIMIT   = 1000000;
  localparam int RANDOM_PIXELS = 600;

  class centerline_area_board;
    logic [LABEL_W-1:0]   road_class_reg = '0;
    logic [CFG_DIM_W-1:0] width_reg      = CFG_DIM_W'(RESET_WIDTH);
    logic [CFG_DIM_W-1:0] height_reg     = CFG_DIM_W'(RESET_HEIGHT);
    logic [STEP_W-1:0]    step_reg       = STEP_W'(RESET_STEP);
    logic [MIN_W_W-1:0]   min_width_reg  = MIN_W_W'(RESET_MIN_W);
    logic [APP_W-1:0]     app_reg        = APP_W'(RESET_APP);

    logic [DIM_W-1:0]     col_cnt    = '0;
    logic [DIM_W-1:0]     row_cnt    = '0;
    logic [DIM_W-1:0]     first_col  = '0;
    logic [DIM_W-1:0]     last_col   = '0;
    logic                 span_seen  = 1'b0;
    logic [TOTAL_W-1:0]   road_total = '0;

    result_t awaited_results[$];
    int      mismatches = 0;

    function logic [CFG_DIM_W-1:0] effective_dim(logic [CFG_DIM_W-1:0] v);
      if (v == '0) return CFG_DIM_W'(1);
      if (v > CFG_DIM_W'(MAX_DIM)) return CFG_DIM_W'(MAX_DIM);
      return v;
    endfunction

    function void set_register(logic [REG_ADDR_W-1:0] idx, logic [REG_DATA_W-1:0] val);
      case (idx)
        REG_ROAD_CLASS:     road_class_reg = val[LABEL_W-1:0];
        REG_FRAME_WIDTH:    width_reg      = val[CFG_DIM_W-1:0];
        REG_FRAME_HEIGHT:   height_reg     = val[CFG_DIM_W-1:0];
        REG_ROW_STEP:       step_reg       = val[STEP_W-1:0];
        REG_MIN_WIDTH:      min_width_reg  = val[MIN_W_W-1:0];
        REG_AREA_PER_PIXEL: app_reg        = val[APP_W-1:0];
        default: ;
      endcase
    endfunction

    function void take_pixel(logic [LABEL_W-1:0] label);
      logic [CFG_DIM_W-1:0] w;
      logic [CFG_DIM_W-1:0] h;
      logic [STEP_W-1:0]    stp;
      logic [DIM_W-1:0]     y;
      logic                 sampled;
      result_t              r;
      w   = effective_dim(width_reg);
      h   = effective_dim(height_reg);
      stp = (step_reg == '0) ? STEP_W'(1) : step_reg;
      if (label == road_class_reg) begin
        if (!span_seen) begin
          first_col = col_cnt;
          span_seen = 1'b1;
        end
        last_col   = col_cnt;
        road_total = road_total + 1'b1;
      end
      if ({1'b0, col_cnt} + 13'd1 >= w) begin
        y = row_cnt;
        sampled = ({1'b0, y} <= h - 13'd1)
                  && (((h - 13'd1 - {1'b0, y}) % {5'b0, stp}) == 13'd0)
                  && ({y, 1'b0} > h);
        if (sampled && span_seen && (last_col - first_col) > min_width_reg) begin
          r              = '0;
          r.kind         = KIND_POINT;
          r.centre_twice = {1'b0, first_col} + {1'b0, last_col};
          r.row_index    = y;
          awaited_results.push_back(r);
        end
        col_cnt   = '0;
        span_seen = 1'b0;
        first_col = '0;
        last_col  = '0;
        if ({1'b0, row_cnt} + 13'd1 >= h) begin
          r            = '0;
          r.kind       = KIND_AREA;
          r.road_area  = AREA_W'({APP_W'(0), road_total} * {TOTAL_W'(0), app_reg});
          r.frame_last = 1'b1;
          awaited_results.push_back(r);
          row_cnt    = '0;
          road_total = '0;
        end else begin
          row_cnt = row_cnt + 1'b1;
        end
      end else begin
        col_cnt = col_cnt + 1'b1;
      end
    endfunction

    task report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      $display("mismatch in %s: got 0x%0h, expected 0x%0h", what, got, want);
      mismatches++;
    endtask

    task check_result(result_t got);
      result_t want;
      if (awaited_results.size() == 0) begin
        report_mismatch("result with none awaited, kind", got.kind, 0);
        return;
      end
      want = awaited_results.pop_front();
      if (got.kind !== want.kind) report_mismatch("kind", got.kind, want.kind);
      if (got.centre_twice !== want.centre_twice)
        report_mismatch("centre_twice", got.centre_twice, want.centre_twice);
      if (got.row_index !== want.row_index)
        report_mismatch("row_index", got.row_index, want.row_index);
      if (got.road_area !== want.road_area)
        report_mismatch("road_area", got.road_area, want.road_area);
      if (got.frame_last !== want.frame_last)
        report_mismatch("frame_last", got.frame_last, want.frame_last);
    endtask
  endclass

  logic                   clk           = 1'b0;
  logic                   rst           = 1'b1;
  logic                   cfg_wr_en     = 1'b0;
  logic [REG_ADDR_W-1:0]  cfg_addr      = '0;
  logic [REG_DATA_W-1:0]  cfg_data      = '0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_DATA_W-1:0]   s_axis_tdata  = '0;  // [7:0] class_label
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  // [12:0] centre_twice, [24:13] row_index, [80:25] road_area, [87:81] zero
  logic [OUT_DATA_W-1:0]  m_axis_tdata;
  logic                   m_axis_tuser;  // [0] kind
  logic                   m_axis_tlast;  // frame_last

  centerline_area_board tracker;
  logic [LABEL_W-1:0]   pixel_q[$];
  result_t              seen;
  int                   src_idle_pct  = 14;
  int                   sink_idle_pct = 83;
  int                   hold_left     = 0;
  int                   cycle_count   = 0;

  road_mask_centerline_scan_core DUT (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_addr      (cfg_addr),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("FAIL");
    $finish;
  end

  initial begin
    forever begin
      @(posedge clk);
      if (m_axis_tvalid && m_axis_tready) begin
        seen.kind         = m_axis_tuser;
        seen.centre_twice = m_axis_tdata[12:0];
        seen.row_index    = m_axis_tdata[24:13];
        seen.road_area    = m_axis_tdata[80:25];
        seen.frame_last   = m_axis_tlast;
        tracker.check_result(seen);
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
      end
    end
  end

  task automatic write_reg(input logic [REG_ADDR_W-1:0] idx, input logic [REG_DATA_W-1:0] val);
    cfg_wr_en <= 1'b1;
    cfg_addr  <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    tracker.set_register(idx, val);
    @(posedge clk);
  endtask

  task automatic send_pixel(input logic [LABEL_W-1:0] label);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= label;
    do @(posedge clk); while (!s_axis_tready);
    tracker.take_pixel(label);
  endtask

  task automatic stream_pixels();
    while (pixel_q.size() != 0) send_pixel(pixel_q.pop_front());
    s_axis_tvalid <= 1'b0;
  endtask

  task automatic wait_idle();
    while (tracker.awaited_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic add_row(input int w, input logic [LABEL_W-1:0] road);
    int                 a;
    int                 b;
    int                 mode;
    logic [LABEL_W-1:0] other;
    mode = $urandom_range(9);
    a    = $urandom_range(w - 1);
    b    = $urandom_range(w - 1, a);
    for (int c = 0; c < w; c++) begin
      other = road ^ 8'($urandom_range(255, 1));
      if (mode < 7) begin
        pixel_q.push_back((c >= a && c <= b && $urandom_range(7) != 0) ? road : other);
      end else begin
        pixel_q.push_back($urandom_range(1) ? road : other);
      end
    end
  endtask

  task automatic random_phase(input int budget);
    int                    fed;
    int                    rows;
    int                    w;
    int                    h;
    logic [REG_DATA_W-1:0] val;
    fed = 0;
    while (fed < budget) begin
      wait_idle();
      if ($urandom_range(1)) begin
        case ($urandom_range(3))
          0:       val = 0;
          1:       val = 255;
          default: val = $urandom_range(255);
        endcase
        write_reg(REG_ROAD_CLASS, val);
      end
      if ($urandom_range(3) != 0) write_reg(REG_FRAME_WIDTH, $urandom_range(10));
      if ($urandom_range(3) != 0) begin
        val = ($urandom_range(15) == 0) ? $urandom_range(40, 11) : $urandom_range(10);
        write_reg(REG_FRAME_HEIGHT, val);
      end
      if ($urandom_range(1)) begin
        case ($urandom_range(7))
          0:       val = 255;
          1:       val = $urandom_range(255);
          default: val = $urandom_range(4);
        endcase
        write_reg(REG_ROW_STEP, val);
      end
      if ($urandom_range(1)) begin
        case ($urandom_range(7))
          0:       val = 4095;
          1:       val = $urandom_range(4095);
          default: val = $urandom_range(4);
        endcase
        write_reg(REG_MIN_WIDTH, val);
      end
      if ($urandom_range(1)) begin
        case ($urandom_range(7))
          0:       val = 0;
          1:       val = 32'hFFFF_FFFF;
          default: val = $urandom;
        endcase
        write_reg(REG_AREA_PER_PIXEL, val);
      end
      w    = tracker.effective_dim(tracker.width_reg);
      h    = tracker.effective_dim(tracker.height_reg);
      rows = $urandom_range(2 * h + 2, 1);
      if (rows * w > 120) rows = 120 / w;
      repeat (rows) add_row(w, tracker.road_class_reg);
      fed += pixel_q.size();
      stream_pixels();
    end
  endtask

  initial begin
    tracker = new;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    write_reg(REG_ROAD_CLASS, 255);
    write_reg(REG_FRAME_WIDTH, 3);
    write_reg(REG_FRAME_HEIGHT, 6);
    write_reg(REG_ROW_STEP, 1);
    write_reg(REG_MIN_WIDTH, 0);
    write_reg(REG_AREA_PER_PIXEL, 32'hFFFF_FFFF);
    pixel_q = '{8'd0, 8'd0, 8'd0, 8'd255, 8'd0, 8'd0, 8'd0, 8'd255, 8'd0,
                8'd255, 8'd255, 8'd255, 8'd0, 8'd255, 8'd0, 8'd255, 8'd0, 8'd255};
    stream_pixels();

    wait_idle();
    write_reg(REG_FRAME_WIDTH, 0);
    write_reg(REG_FRAME_HEIGHT, 0);
    write_reg(REG_ROW_STEP, 0);
    pixel_q = '{8'd255, 8'd17};
    stream_pixels();

    wait_idle();
    write_reg(REG_FRAME_WIDTH, 8191);
    write_reg(REG_FRAME_HEIGHT, 4097);
    pixel_q = '{8'd255, 8'd1, 8'd255};
    stream_pixels();
    wait_idle();
    write_reg(REG_FRAME_WIDTH, 2);
    pixel_q = '{8'd255};
    stream_pixels();
    wait_idle();
    write_reg(REG_FRAME_HEIGHT, 1);
    pixel_q = '{8'd255, 8'd255};
    stream_pixels();

    random_phase(RANDOM_PIXELS / 3);
    src_idle_pct  = 83;
    sink_idle_pct = 14;
    random_phase(RANDOM_PIXELS / 3);
    src_idle_pct  = 0;
    sink_idle_pct = 0;
    random_phase(RANDOM_PIXELS / 3);

    // Hold the output off long enough to fill the result queue and stall the input.
    wait_idle();
    write_reg(REG_FRAME_WIDTH, 1);
    write_reg(REG_FRAME_HEIGHT, 1);
    hold_left = 300;
    repeat (40) pixel_q.push_back($urandom_range(1) ? tracker.road_class_reg
                                                    : 8'($urandom_range(255)));
    stream_pixels();

    wait_idle();
    write_reg(REG_ROAD_CLASS, 7);
    write_reg(REG_FRAME_WIDTH, 64);
    write_reg(REG_FRAME_HEIGHT, 3);
    write_reg(REG_ROW_STEP, 1);
    write_reg(REG_MIN_WIDTH, 0);
    write_reg(REG_AREA_PER_PIXEL, $urandom);
    repeat (3) add_row(64, 8'd7);
    stream_pixels();

    wait_idle();
    write_reg(REG_FRAME_WIDTH, 2);
    write_reg(REG_FRAME_HEIGHT, 150);
    write_reg(REG_ROW_STEP, 37);
    repeat (150) add_row(2, 8'd7);
    stream_pixels();

    while (tracker.awaited_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (tracker.mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ----- road_mask_centerline_scan_core.f -----
design/rmcs_pkg.sv
design/road_mask_centerline_scan_core.sv
dv/road_mask_centerline_scan_core_test.sv
